[src/assert_macros.svh]
// Assertion macros used by the port-level checker file.
// Depends on nothing; the including scope supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with explicit clock and active-low reset
`define ASSERT_CLK(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Assertion on the scope's clk and rst_n
`define ASSERT_STD(lbl, prop, msg) `ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

[src/idpr_pkg.sv]
// Package for the int8 dot product and requantize block.
// Holds controller states, command struct, configuration struct and register indexes.
package idpr_pkg;

  typedef enum logic [1:0] {
    S_ACC,
    S_MUL,
    S_DBL,
    S_FIN
  } state_t;

  typedef struct packed {
    logic acc_en;
    logic mul_en;
    logic dbl_en;
    logic fin_en;
  } cmd_t;

  typedef struct packed {
    logic signed [8:0] act_offset;
    logic signed [8:0] weight_offset;
    logic signed [7:0] zero_point;
    logic [30:0]       out_multiplier;
    logic signed [5:0] out_shift;
    logic signed [7:0] act_min;
    logic signed [7:0] act_max;
  } cfg_t;

  localparam int unsigned ADDR_W = 5;

  localparam logic [2:0] REG_ACT_OFFSET     = 3'd0;
  localparam logic [2:0] REG_WEIGHT_OFFSET  = 3'd1;
  localparam logic [2:0] REG_ZERO_POINT     = 3'd2;
  localparam logic [2:0] REG_OUT_MULTIPLIER = 3'd3;
  localparam logic [2:0] REG_OUT_SHIFT      = 3'd4;
  localparam logic [2:0] REG_ACT_MIN        = 3'd5;
  localparam logic [2:0] REG_ACT_MAX        = 3'd6;

  localparam logic [30:0] MULT_RESET = 31'd1073741824;

endpackage

[src/idpr_cfg.sv]
// Configuration register file behind the APB-style port.
// Depends on idpr_pkg for the register struct and register indexes.
module idpr_cfg
  import idpr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [2:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        REG_ACT_OFFSET:     cfg_nxt.act_offset     = pwdata[8:0];
        REG_WEIGHT_OFFSET:  cfg_nxt.weight_offset  = pwdata[8:0];
        REG_ZERO_POINT:     cfg_nxt.zero_point     = pwdata[7:0];
        REG_OUT_MULTIPLIER: cfg_nxt.out_multiplier = pwdata[30:0];
        REG_OUT_SHIFT:      cfg_nxt.out_shift      = pwdata[5:0];
        REG_ACT_MIN:        cfg_nxt.act_min        = pwdata[7:0];
        REG_ACT_MAX:        cfg_nxt.act_max        = pwdata[7:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ACT_OFFSET:     prdata = {23'd0, cfg_r.act_offset};
      REG_WEIGHT_OFFSET:  prdata = {23'd0, cfg_r.weight_offset};
      REG_ZERO_POINT:     prdata = {24'd0, cfg_r.zero_point};
      REG_OUT_MULTIPLIER: prdata = {1'b0, cfg_r.out_multiplier};
      REG_OUT_SHIFT:      prdata = {26'd0, cfg_r.out_shift};
      REG_ACT_MIN:        prdata = {24'd0, cfg_r.act_min};
      REG_ACT_MAX:        prdata = {24'd0, cfg_r.act_max};
      default:            prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.act_offset     <= 9'sd0;
      cfg_r.weight_offset  <= 9'sd0;
      cfg_r.zero_point     <= 8'sd0;
      cfg_r.out_multiplier <= MULT_RESET;
      cfg_r.out_shift      <= 6'sd0;
      cfg_r.act_min        <= -8'sd128;
      cfg_r.act_max        <= 8'sd127;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[src/idpr_ctrl.sv]
// Controller: sequences accumulate, multiply, high-word and finish steps.
// Depends on idpr_pkg for state_t and cmd_t; owns the output valid flag.
module idpr_ctrl
  import idpr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_last_element,
  output logic in_stall,
  input  logic out_stall,
  output logic out_valid,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_ACC: begin
        if (in_valid && in_last_element) state_nxt = S_MUL;
      end
      S_MUL: state_nxt = S_DBL;
      S_DBL: state_nxt = S_FIN;
      S_FIN: begin
        if (!out_valid_r || !out_stall) state_nxt = S_ACC;
      end
      default: state_nxt = S_ACC;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_ACC: begin
        in_stall   = 1'b0;
        cmd.acc_en = in_valid;
      end
      S_MUL: cmd.mul_en = 1'b1;
      S_DBL: cmd.dbl_en = 1'b1;
      S_FIN: cmd.fin_en = !out_valid_r || !out_stall;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.fin_en) out_valid_nxt = 1'b1;
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[src/idpr_dp.sv]
// Datapath: multiply-accumulate, doubling high multiply, rounding shift, clamp.
// Depends on idpr_pkg for cmd_t and cfg_t.
module idpr_dp
  import idpr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  input  cfg_t              cfg,
  input  logic signed [7:0] in_value,
  input  logic signed [7:0] in_weight,
  input  logic [31:0]       in_bias,
  input  logic              in_last_element,
  output logic signed [7:0] out_value
);

  logic [31:0]        acc_r;
  logic [31:0]        acc_nxt;
  logic [31:0]        sum_r;
  logic signed [63:0] prod_r;
  logic [31:0]        dbl_r;
  logic signed [7:0]  out_value_r;

  logic signed [9:0]  act_s;
  logic signed [9:0]  wgt_s;
  logic signed [19:0] mac_s;
  logic [31:0]        mac_ext;
  logic [31:0]        acc_sum;

  logic [4:0]         lsh;
  logic signed [31:0] shifted_s;
  logic signed [31:0] mult_s;
  logic signed [63:0] prod_nxt;

  logic signed [63:0] nudge;
  logic signed [63:0] rnd_s;
  logic signed [63:0] hi_s;
  logic [31:0]        dbl_nxt;

  logic [5:0]         shift_mag;
  logic [4:0]         rsh;
  logic [31:0]        mask;
  logic [31:0]        rem;
  logic [31:0]        thr;
  logic signed [31:0] shr_s;
  logic signed [31:0] q_s;
  logic signed [32:0] v_s;
  logic signed [32:0] min_s;
  logic signed [32:0] max_s;
  logic signed [32:0] clamp_s;

  // accumulate
  assign act_s   = 10'(in_value) + 10'(cfg.act_offset);
  assign wgt_s   = 10'(in_weight) + 10'(cfg.weight_offset);
  assign mac_s   = act_s * wgt_s;
  assign mac_ext = 32'(mac_s);
  assign acc_sum = acc_r + mac_ext + (in_last_element ? in_bias : 32'd0);

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.acc_en) acc_nxt = in_last_element ? 32'd0 : acc_sum;
  end

  // left shift and multiply
  assign lsh       = (!cfg.out_shift[5]) ? cfg.out_shift[4:0] : 5'd0;
  assign shifted_s = $signed(sum_r << lsh);
  assign mult_s    = $signed({1'b0, cfg.out_multiplier});
  assign prod_nxt  = shifted_s * mult_s;

  // rounded high word, truncated towards zero
  assign nudge   = prod_r[63] ? (64'sd1 - 64'sd1073741824) : 64'sd1073741824;
  assign rnd_s   = prod_r + nudge;
  assign hi_s    = rnd_s >>> 31;
  assign dbl_nxt = hi_s[31:0] + {31'd0, rnd_s[63] && (|rnd_s[30:0])};

  // rounding right shift, offset and clamp
  assign shift_mag = 6'(-cfg.out_shift);
  assign rsh       = (!cfg.out_shift[5]) ? 5'd0 : (shift_mag[5] ? 5'd31 : shift_mag[4:0]);
  assign mask      = (32'd1 << rsh) - 32'd1;
  assign rem       = dbl_r & mask;
  assign thr       = (mask >> 1) + {31'd0, dbl_r[31]};
  assign shr_s     = $signed(dbl_r) >>> rsh;
  assign q_s       = shr_s + $signed({31'd0, rem > thr});
  assign v_s       = 33'(q_s) + 33'(cfg.zero_point);
  assign min_s     = 33'(cfg.act_min);
  assign max_s     = 33'(cfg.act_max);

  always_comb begin
    clamp_s = v_s;
    if (clamp_s < min_s) clamp_s = min_s;
    if (clamp_s > max_s) clamp_s = max_s;
  end

  assign out_value = out_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 32'd0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_en && in_last_element) sum_r <= acc_sum;
    if (cmd.mul_en) prod_r <= prod_nxt;
    if (cmd.dbl_en) dbl_r <= dbl_nxt;
    if (cmd.fin_en) out_value_r <= clamp_s[7:0];
  end

endmodule

[src/int8_dot_product_requantize.sv]
// Int8 dot product with requantize. Throughput: one element pair per cycle;
// after the last element of a vector the input stalls through the multiply,
// high-word and finish steps, longer only while a finished result is still stalled.
// out_valid is registered and rises once the finish step has run.
// Reset (rst_n low, synchronous) clears the accumulator, controller and config.
module int8_dot_product_requantize
  import idpr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [7:0]    in_value,
  input  logic signed [7:0]    in_weight,
  input  logic signed [31:0]   in_bias,
  input  logic                 in_last_element,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [7:0]    out_value
);

  cfg_t cfg;
  cmd_t cmd;

  idpr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  idpr_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_last_element (in_last_element),
    .in_stall        (in_stall),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .cmd             (cmd)
  );

  idpr_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg             (cfg),
    .in_value        (in_value),
    .in_weight       (in_weight),
    .in_bias         (in_bias),
    .in_last_element (in_last_element),
    .out_value       (out_value)
  );

endmodule

[src/idpr_checker.sv]
// Port-level checker for the int8 dot product block, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module idpr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_last_element,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_value
);

  `ASSERT_STD(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `ASSERT_STD(a_out_stable, out_valid && out_stall |=> $stable(out_value), "stalled result changed")
  `ASSERT_STD(a_busy_after_last, in_valid && !in_stall && in_last_element |=> in_stall, "input taken during requantize")
  `ASSERT_STD(a_result_due, in_valid && !in_stall && in_last_element |=> ##3 out_valid, "result missing after last element")

endmodule

bind int8_dot_product_requantize idpr_checker u_idpr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_last_element (in_last_element),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_value       (out_value)
);
